### sv/sct_pkg.sv
// Shared types, token kind codes and character tables for the source code tokenizer.
// No dependencies; used by source_code_tokenizer and sct_checker.
package sct_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int LEN_BITS_DEF = 16;
    localparam int KW_BYTES     = 7;
    localparam int KW_COUNT     = 12;
    localparam int OP_COUNT     = 6;
    localparam int PUNCT_COUNT  = 14;

    typedef logic [5:0] kind_t;

    localparam kind_t K_DOT     = 6'd11;
    localparam kind_t K_ASSIGN  = 6'd14;
    localparam kind_t K_EQ_EQ   = 6'd15;
    localparam kind_t K_GT      = 6'd16;
    localparam kind_t K_GT_EQ   = 6'd17;
    localparam kind_t K_LT      = 6'd18;
    localparam kind_t K_LT_EQ   = 6'd19;
    localparam kind_t K_AMP     = 6'd20;
    localparam kind_t K_AND_AND = 6'd21;
    localparam kind_t K_BAR     = 6'd22;
    localparam kind_t K_OR_OR   = 6'd23;
    localparam kind_t K_BANG    = 6'd24;
    localparam kind_t K_NOT_EQ  = 6'd25;
    localparam kind_t K_IDENT   = 6'd38;
    localparam kind_t K_INTLIT  = 6'd39;
    localparam kind_t K_DECLIT  = 6'd40;
    localparam kind_t K_STRLIT  = 6'd41;
    localparam kind_t K_COMMENT = 6'd42;
    localparam kind_t K_UNKNOWN = 6'd43;
    localparam kind_t K_ERROR   = 6'd44;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [15:0] length;
    } tok_t;

    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'h6966,           56'h656C7365,       56'h666F72,         56'h7768696C65,
        56'h66756E63,       56'h696E74,         56'h646F75626C65,   56'h666C6F6174,
        56'h737472696E67,   56'h626F6F6C65616E, 56'h766F6964,       56'h6E756C6C
    };
    localparam int KW_LEN [KW_COUNT] = '{2, 4, 3, 5, 4, 3, 6, 5, 6, 7, 4, 4};
    localparam kind_t KW_KIND [KW_COUNT] = '{
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37
    };

    localparam logic [7:0] OP_FIRST  [OP_COUNT] = '{8'h3D, 8'h3E, 8'h3C, 8'h26, 8'h7C, 8'h21};
    localparam logic [7:0] OP_SECOND [OP_COUNT] = '{8'h3D, 8'h3D, 8'h3D, 8'h26, 8'h7C, 8'h3D};
    localparam kind_t OP_SINGLE [OP_COUNT] = '{K_ASSIGN, K_GT, K_LT, K_AMP, K_BAR, K_BANG};
    localparam kind_t OP_PAIR   [OP_COUNT] = '{K_EQ_EQ, K_GT_EQ, K_LT_EQ, K_AND_AND, K_OR_OR,
                                               K_NOT_EQ};

    localparam logic [7:0] PUNCT [PUNCT_COUNT] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h5B,
        8'h5D, 8'h7B, 8'h7D, 8'h2C, 8'h2E, 8'h3B, 8'h3A
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
    endfunction

endpackage

### sv/source_code_tokenizer.sv
// A byte's tokens enter the result queue as it is accepted; m_ shows the queue head.
// Throughput: one byte per cycle unless stalled; a byte that closes one token and makes
// another pushes two entries to a four-entry result queue that stalls input above two.
// Reset: synchronous active-low aresetn returns to idle at offset zero and empties the queue.
// Streaming tokenizer top level: mode update, keyword match and result queue.
// Depends on sct_pkg.
module source_code_tokenizer #(
    parameter int POS_BITS = sct_pkg::POS_BITS_DEF,
    parameter int LEN_BITS = sct_pkg::LEN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_COMMENT, MODE_OPER
    } mode_t;

    typedef struct packed {
        logic          v;
        sct_pkg::tok_t tok;
    } res_t;

    typedef struct packed {
        sct_pkg::tok_t tok;
        logic          last;
    } qent_t;

    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [2:0]          pend_reg, pend_next;
    logic                dec_reg, dec_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] offset_reg, offset_next;
    logic [55:0]         kw_reg, kw_next;
    logic [LEN_BITS-1:0] cnt_reg, cnt_next;
    qent_t               q_reg [QDEPTH];
    qent_t               q_next [QDEPTH];
    logic [QCW-1:0]      qcnt_reg, qcnt_next;

    logic          s_accept;
    logic          pop;
    logic          consumed;
    logic          op_hit, punct_hit;
    logic [2:0]    op_idx;
    logic [3:0]    punct_idx;
    res_t          p1, p2, p3;
    sct_pkg::tok_t r0, r1;
    logic [1:0]    nres, push_n;
    logic [QCW-1:0] base;

    function automatic logic [31:0] pos32(input logic [POS_BITS-1:0] p);
        logic [47:0] w;
        w = 48'(p);
        return w[31:0];
    endfunction

    function automatic logic [15:0] len16(input logic [LEN_BITS-1:0] n);
        logic [31:0] w;
        w = 32'(n);
        return w[15:0];
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] n);
        return (n == LEN_MAX) ? n : n + LEN_BITS'(1);
    endfunction

    function automatic sct_pkg::kind_t kw_kind(input logic [55:0] kb,
                                               input logic [LEN_BITS-1:0] n);
        sct_pkg::kind_t k;
        k = sct_pkg::K_IDENT;
        for (int i = sct_pkg::KW_COUNT - 1; i >= 0; i--) begin
            if (n == LEN_BITS'(sct_pkg::KW_LEN[i]) && kb == sct_pkg::KW_TEXT[i]) begin
                k = sct_pkg::KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic res_t flush_tok(input mode_t md, input logic [2:0] pe, input logic dc,
                                       input logic [POS_BITS-1:0] sp, input logic [55:0] kb,
                                       input logic [LEN_BITS-1:0] n);
        res_t f;
        logic [2:0] oi;
        oi = pe - 3'd1;
        f.v = 1'b1;
        f.tok.kind = sct_pkg::K_IDENT;
        f.tok.start = pos32(sp);
        f.tok.length = len16(n);
        case (md)
            MODE_IDENT: begin
                f.tok.kind = kw_kind(kb, n);
            end
            MODE_NUMBER: begin
                f.tok.kind = dc ? sct_pkg::K_DECLIT : sct_pkg::K_INTLIT;
            end
            MODE_STRING: begin
                f.tok.kind = sct_pkg::K_ERROR;
            end
            MODE_COMMENT: begin
                f.tok.kind = sct_pkg::K_COMMENT;
            end
            MODE_OPER: begin
                if (pe >= 3'd1 && pe <= 3'd6) begin
                    f.tok.kind = sct_pkg::OP_SINGLE[oi];
                    f.tok.length = 16'd1;
                end else begin
                    f.v = 1'b0;
                end
            end
            default: begin
                f.v = 1'b0;
            end
        endcase
        return f;
    endfunction

    always_comb begin
        op_hit = 1'b0;
        op_idx = '0;
        for (int i = sct_pkg::OP_COUNT - 1; i >= 0; i--) begin
            if (s_char_byte == sct_pkg::OP_FIRST[i]) begin
                op_hit = 1'b1;
                op_idx = 3'(i);
            end
        end
        punct_hit = 1'b0;
        punct_idx = '0;
        for (int i = sct_pkg::PUNCT_COUNT - 1; i >= 0; i--) begin
            if (s_char_byte == sct_pkg::PUNCT[i]) begin
                punct_hit = 1'b1;
                punct_idx = 4'(i);
            end
        end
    end

    always_comb begin
        logic [2:0] pi;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        dec_next    = dec_reg;
        start_next  = start_reg;
        kw_next     = kw_reg;
        cnt_next    = cnt_reg;
        consumed    = 1'b0;
        p1          = '0;
        p2          = '0;
        p3          = '0;
        pi          = pend_reg - 3'd1;

        case (mode_reg)
            MODE_IDENT: begin
                if (sct_pkg::is_word(s_char_byte)) begin
                    if (cnt_reg < LEN_BITS'(sct_pkg::KW_BYTES)) begin
                        kw_next = {kw_reg[47:0], s_char_byte};
                    end
                    cnt_next = sat_inc(cnt_reg);
                    consumed = 1'b1;
                end else begin
                    p1 = flush_tok(mode_reg, pend_reg, dec_reg, start_reg, kw_reg, cnt_reg);
                    mode_next = MODE_IDLE;
                    pend_next = '0;
                end
            end
            MODE_NUMBER: begin
                if (sct_pkg::is_digit(s_char_byte)) begin
                    cnt_next = sat_inc(cnt_reg);
                    consumed = 1'b1;
                end else if (s_char_byte == sct_pkg::CH_DOT && !dec_reg) begin
                    dec_next = 1'b1;
                    cnt_next = sat_inc(cnt_reg);
                    consumed = 1'b1;
                end else begin
                    p1 = flush_tok(mode_reg, pend_reg, dec_reg, start_reg, kw_reg, cnt_reg);
                    mode_next = MODE_IDLE;
                    pend_next = '0;
                end
            end
            MODE_OPER: begin
                if (pend_reg >= 3'd1 && pend_reg <= 3'd6 &&
                    s_char_byte == sct_pkg::OP_SECOND[pi]) begin
                    p1.v = 1'b1;
                    p1.tok.kind = sct_pkg::OP_PAIR[pi];
                    p1.tok.start = pos32(start_reg);
                    p1.tok.length = 16'd2;
                    consumed = 1'b1;
                end else begin
                    p1 = flush_tok(mode_reg, pend_reg, dec_reg, start_reg, kw_reg, cnt_reg);
                end
                mode_next = MODE_IDLE;
                pend_next = '0;
            end
            MODE_STRING: begin
                if (s_char_byte == sct_pkg::CH_QUOTE) begin
                    p1.v = 1'b1;
                    p1.tok.kind = sct_pkg::K_STRLIT;
                    p1.tok.start = pos32(start_reg);
                    p1.tok.length = len16(cnt_reg);
                    mode_next = MODE_IDLE;
                end else begin
                    cnt_next = sat_inc(cnt_reg);
                end
                consumed = 1'b1;
            end
            MODE_COMMENT: begin
                if (s_char_byte == sct_pkg::CH_NEWLINE) begin
                    p1 = flush_tok(mode_reg, pend_reg, dec_reg, start_reg, kw_reg, cnt_reg);
                    mode_next = MODE_IDLE;
                    pend_next = '0;
                end else begin
                    cnt_next = sat_inc(cnt_reg);
                    consumed = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!consumed && !sct_pkg::is_space(s_char_byte)) begin
            if (sct_pkg::is_alpha(s_char_byte) || s_char_byte == sct_pkg::CH_UNDERSCORE ||
                sct_pkg::is_digit(s_char_byte) || s_char_byte == sct_pkg::CH_QUOTE ||
                s_char_byte == sct_pkg::CH_HASH || op_hit) begin
                start_next = offset_reg;
                cnt_next   = LEN_BITS'(1);
                kw_next    = '0;
                dec_next   = 1'b0;
                pend_next  = '0;
                if (sct_pkg::is_alpha(s_char_byte) ||
                    s_char_byte == sct_pkg::CH_UNDERSCORE) begin
                    mode_next = MODE_IDENT;
                    kw_next   = {48'd0, s_char_byte};
                end else if (sct_pkg::is_digit(s_char_byte)) begin
                    mode_next = MODE_NUMBER;
                end else if (s_char_byte == sct_pkg::CH_QUOTE) begin
                    mode_next  = MODE_STRING;
                    start_next = offset_reg + POS_BITS'(1);
                    cnt_next   = '0;
                end else if (s_char_byte == sct_pkg::CH_HASH) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    mode_next = MODE_OPER;
                    pend_next = op_idx + 3'd1;
                end
            end else begin
                p2.v = 1'b1;
                p2.tok.kind = punct_hit ? sct_pkg::kind_t'(punct_idx) : sct_pkg::K_UNKNOWN;
                p2.tok.start = pos32(offset_reg);
                p2.tok.length = 16'd1;
            end
        end

        if (s_end_of_input) begin
            p3 = flush_tok(mode_next, pend_next, dec_next, start_next, kw_next, cnt_next);
            mode_next   = MODE_IDLE;
            pend_next   = '0;
            offset_next = '0;
        end else begin
            offset_next = offset_reg + POS_BITS'(1);
        end
    end

    always_comb begin
        r0   = p1.v ? p1.tok : (p2.v ? p2.tok : p3.tok);
        r1   = (p1.v && p2.v) ? p2.tok : p3.tok;
        nres = 2'(p1.v) + 2'(p2.v) + 2'(p3.v);
    end

    assign s_accept = s_valid && s_ready;
    assign pop      = m_valid && m_ready;
    assign push_n   = s_accept ? nres : 2'd0;
    assign base     = qcnt_reg - QCW'(pop);

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_next[i] = q_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (push_n != 2'd0 && base == QCW'(i)) begin
                q_next[i] = '{tok: r0, last: push_n == 2'd1};
            end
            if (push_n == 2'd2 && base + QCW'(1) == QCW'(i)) begin
                q_next[i] = '{tok: r1, last: 1'b1};
            end
        end
        qcnt_next = base + QCW'(push_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            dec_reg    <= 1'b0;
            start_reg  <= '0;
            offset_reg <= '0;
            kw_reg     <= '0;
            cnt_reg    <= '0;
            qcnt_reg   <= '0;
        end else begin
            if (s_accept) begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                dec_reg    <= dec_next;
                start_reg  <= start_next;
                offset_reg <= offset_next;
                kw_reg     <= kw_next;
                cnt_reg    <= cnt_next;
            end
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign s_ready        = qcnt_reg <= QCW'(QDEPTH - 2);
    assign m_valid        = qcnt_reg != '0;
    assign m_token_kind   = q_reg[0].tok.kind;
    assign m_token_start  = q_reg[0].tok.start;
    assign m_token_length = q_reg[0].tok.length;
    assign m_last_of_run  = q_reg[0].last;

endmodule

### sv/sct_checker.sv
// Port-level checks for the tokenizer's result channel, bound to the top level.
// Depends on sct_pkg and source_code_tokenizer.
module sct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_token_kind,
    input logic [15:0] m_token_length
);

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= sct_pkg::K_ERROR)
        else $error("token kind out of range");

    a_pair_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == sct_pkg::K_EQ_EQ || m_token_kind == sct_pkg::K_GT_EQ ||
                    m_token_kind == sct_pkg::K_LT_EQ || m_token_kind == sct_pkg::K_AND_AND ||
                    m_token_kind == sct_pkg::K_OR_OR || m_token_kind == sct_pkg::K_NOT_EQ)
        |-> m_token_length == 16'd2)
        else $error("two-byte operator with wrong length");

    a_single_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind <= sct_pkg::K_ASSIGN || m_token_kind == sct_pkg::K_GT ||
                    m_token_kind == sct_pkg::K_LT || m_token_kind == sct_pkg::K_AMP ||
                    m_token_kind == sct_pkg::K_BAR || m_token_kind == sct_pkg::K_BANG ||
                    m_token_kind == sct_pkg::K_UNKNOWN)
        |-> m_token_length == 16'd1)
        else $error("single-byte token with wrong length");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("queue not empty after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_token_length))
        else $error("stalled transaction changed");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_length (m_token_length)
);
